FILE: rtl/iir_direct_form_two_filter_defines.svh
// ---------------------------------------------------------------------------
// IIR direct form II filter: assertion macros
// Shared shorthand for the concurrent checks. Expects clk and arst_n in scope.
// ---------------------------------------------------------------------------
`ifndef IIR_DIRECT_FORM_TWO_FILTER_DEFINES_SVH
`define IIR_DIRECT_FORM_TWO_FILTER_DEFINES_SVH

// check sampled on clk, switched off while reset is asserted
`define IIRDF2_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) \
		else $error(msg);

// check that also holds while reset is asserted
`define IIRDF2_ASSERT_RST(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

FILE: rtl/iirdf2_pkg.sv
// ---------------------------------------------------------------------------
// IIR direct form II filter: package
// Fixed widths, register map and request op codes.
// ---------------------------------------------------------------------------
package iirdf2_pkg;

	localparam int MAX_ORDER       = 3;
	localparam int SAMPLE_BITS_DEF = 16;
	localparam int COEF_FRAC_BITS  = 14;
	localparam int COEF_BITS       = 18;
	localparam int STATE_BITS      = 24;
	localparam int ORDER_BITS      = 2;

	// register file: order, b0..b3, a1..a3, 32-bit words
	localparam int NUM_REGS     = 8;
	localparam int DATA_BITS    = 32;
	localparam int ADDR_BITS    = $clog2(NUM_REGS * 4);
	localparam int REG_IDX_BITS = $clog2(NUM_REGS);

	typedef logic [REG_IDX_BITS-1:0] reg_idx_t;
	typedef logic signed [COEF_BITS-1:0] coef_t;
	typedef logic signed [STATE_BITS-1:0] state_t;

	localparam reg_idx_t REG_ORDER = reg_idx_t'(0);
	localparam reg_idx_t REG_NUM_0 = reg_idx_t'(1);
	localparam reg_idx_t REG_DEN_1 = reg_idx_t'(5);

	// request op codes
	localparam logic OP_FILTER = 1'b0;
	localparam logic OP_CLEAR  = 1'b1;

endpackage

FILE: rtl/iirdf2_if.sv
// ---------------------------------------------------------------------------
// IIR direct form II filter: channel interfaces
// Request channel (op, sample) and result channel (sample, clip flag).
// ---------------------------------------------------------------------------
interface iirdf2_req_if import iirdf2_pkg::*; #(
	parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
);
	logic                          valid;
	logic                          ready;
	logic                          op;
	logic signed [SAMPLE_BITS-1:0] sample_in;

	modport source (output valid, output op, output sample_in, input ready);
	modport sink (input valid, input op, input sample_in, output ready);
endinterface

interface iirdf2_rsp_if import iirdf2_pkg::*; #(
	parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
);
	logic                          valid;
	logic                          ready;
	logic signed [SAMPLE_BITS-1:0] sample_out;
	logic                          clipped;

	modport source (output valid, output sample_out, output clipped, input ready);
	modport sink (input valid, input sample_out, input clipped, output ready);
endinterface

FILE: rtl/iir_direct_form_two_filter.sv
// A filter request of order n>0 passes through the tap loop, drain, b0*v and final states;
//   order 0 goes straight to b0*v. A clear request gives no result and leaves the block idle.
// A new request is taken only when idle, and the single 18x24 multiplier serves all
//   2n+1 products of a request in turn.
// Reset (arst_n low, asynchronous): delay line zeroed, order 0, b0 = 1.0, other coefs 0.
// ---------------------------------------------------------------------------
// IIR direct form II filter
// One shared multiplier and two accumulators under a small sequencer. Per sample:
//   fb  = x*2^F - sum(a_i*w_i)   (feedback accumulator)
//   acc =         sum(b_i*w_i)   (feed-forward accumulator)
//   v   = sat24(round(fb)), delay line shifts in v
//   y   = sat(round(acc + b0*v))
// Products are registered and added in the cycle after they are issued, so the
// multiplier issues a new product every cycle of the tap loop.
// ---------------------------------------------------------------------------
module iir_direct_form_two_filter import iirdf2_pkg::*; #(
	parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
) (
	input  logic                 clk,
	input  logic                 arst_n,
	// APB-style register port
	input  logic                 psel,
	input  logic                 penable,
	input  logic                 pwrite,
	input  logic [ADDR_BITS-1:0] paddr,
	input  logic [DATA_BITS-1:0] pwdata,
	output logic [DATA_BITS-1:0] prdata,
	output logic                 pready,
	// request and result channels
	iirdf2_req_if.sink           sample,
	iirdf2_rsp_if.source         result
);

	localparam int PROD_BITS = COEF_BITS + STATE_BITS;
	// room for x*2^F plus 2*MAX_ORDER+1 products
	localparam int ACC_BITS  = PROD_BITS + 3;
	localparam int PH_BITS   = $clog2(2 * MAX_ORDER);
	localparam int TAP_BITS  = PH_BITS - 1;
	localparam int X_PAD     = ACC_BITS - SAMPLE_BITS - COEF_FRAC_BITS;

	localparam logic signed [ACC_BITS-1:0] RND_HALF =
		ACC_BITS'(64'sd1 <<< (COEF_FRAC_BITS - 1));
	localparam logic signed [ACC_BITS-1:0] ST_HI =
		ACC_BITS'((64'sd1 <<< (STATE_BITS - 1)) - 64'sd1);
	localparam logic signed [ACC_BITS-1:0] ST_LO =
		ACC_BITS'(-(64'sd1 <<< (STATE_BITS - 1)));
	localparam logic signed [ACC_BITS-1:0] SM_HI =
		ACC_BITS'((64'sd1 <<< (SAMPLE_BITS - 1)) - 64'sd1);
	localparam logic signed [ACC_BITS-1:0] SM_LO =
		ACC_BITS'(-(64'sd1 <<< (SAMPLE_BITS - 1)));
	localparam coef_t B0_RESET = coef_t'(64'sd1 <<< COEF_FRAC_BITS);

	// sequencer states
	localparam logic [2:0] ST_IDLE  = 3'd0; // waiting for a request
	localparam logic [2:0] ST_MAC   = 3'd1; // tap products a1,b1,a2,b2,...
	localparam logic [2:0] ST_DRAIN = 3'd2; // last b product, form v, shift taps
	localparam logic [2:0] ST_VMUL  = 3'd3; // b0*v
	localparam logic [2:0] ST_VACC  = 3'd4; // add b0*v
	localparam logic [2:0] ST_FIN   = 3'd5; // round/saturate y, load result reg

	// configuration
	logic [ORDER_BITS-1:0] order_q;
	coef_t                 b0_q;
	coef_t                 num_q [MAX_ORDER]; // b1..bN
	coef_t                 den_q [MAX_ORDER]; // a1..aN
	logic                  cfg_wr;
	reg_idx_t              cfg_idx;
	logic [ORDER_BITS-1:0] ord_eff;

	// datapath
	state_t                         dl_q [MAX_ORDER];
	logic [2:0]                     state_q;
	logic [PH_BITS-1:0]             ph_q;
	logic [PH_BITS-1:0]             ph_last;
	logic [TAP_BITS-1:0]            tap;
	logic signed [ACC_BITS-1:0]     fb_q;
	logic signed [ACC_BITS-1:0]     acc_q;
	logic signed [PROD_BITS-1:0]    prod_q;
	logic signed [ACC_BITS-1:0]     prod_ext;
	state_t                         v_q;
	logic                           hit_q;
	coef_t                          mul_c;
	state_t                         mul_d;
	logic signed [ACC_BITS-1:0]     fb_rnd;
	logic signed [ACC_BITS-1:0]     acc_rnd;
	logic                           v_clip;
	state_t                         v_next;
	logic                           y_clip;
	logic signed [SAMPLE_BITS-1:0]  y_next;
	logic                           req_acc;
	logic                           res_load;

	// result register
	logic                           res_valid_q;
	logic signed [SAMPLE_BITS-1:0]  res_sample_q;
	logic                           res_clip_q;

	// ---------------- register port ----------------
	assign pready  = 1'b1;
	assign cfg_wr  = psel && penable && pwrite && pready;
	assign cfg_idx = paddr[ADDR_BITS-1:2];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			order_q <= '0;
			b0_q    <= B0_RESET;
			for (int k = 0; k < MAX_ORDER; k++) begin
				num_q[k] <= '0;
				den_q[k] <= '0;
			end
		end else if (cfg_wr) begin
			case (cfg_idx)
				REG_ORDER: order_q <= pwdata[ORDER_BITS-1:0];
				REG_NUM_0: b0_q    <= pwdata[COEF_BITS-1:0];
				default: begin
					for (int k = 0; k < MAX_ORDER; k++) begin
						if (cfg_idx == reg_idx_t'(int'(REG_NUM_0) + 1 + k))
							num_q[k] <= pwdata[COEF_BITS-1:0];
						if (cfg_idx == reg_idx_t'(int'(REG_DEN_1) + k))
							den_q[k] <= pwdata[COEF_BITS-1:0];
					end
				end
			endcase
		end
	end

	// read back, coefficients sign-extended
	always_comb begin
		prdata = '0;
		case (cfg_idx)
			REG_ORDER: prdata = DATA_BITS'(order_q);
			REG_NUM_0: prdata = DATA_BITS'(b0_q);
			default: begin
				for (int k = 0; k < MAX_ORDER; k++) begin
					if (cfg_idx == reg_idx_t'(int'(REG_NUM_0) + 1 + k))
						prdata = DATA_BITS'(num_q[k]);
					if (cfg_idx == reg_idx_t'(int'(REG_DEN_1) + k))
						prdata = DATA_BITS'(den_q[k]);
				end
			end
		endcase
	end

	// orders above the tap count run as the full filter
	assign ord_eff = (order_q > ORDER_BITS'(MAX_ORDER)) ? ORDER_BITS'(MAX_ORDER) : order_q;

	// ---------------- sequencer control ----------------
	assign sample.ready = (state_q == ST_IDLE);
	assign req_acc      = sample.valid && sample.ready;
	// last tap product index: 2*order - 1
	assign ph_last      = PH_BITS'({ord_eff, 1'b0}) - PH_BITS'(1);
	// result register free, or being emptied this cycle
	assign res_load     = (state_q == ST_FIN) && (!res_valid_q || result.ready);

	// even phase: a_i, odd phase: b_i, both on tap i
	assign tap = ph_q[PH_BITS-1:1];

	always_comb begin
		if (state_q == ST_MAC) begin
			mul_c = ph_q[0] ? num_q[tap] : den_q[tap];
			mul_d = dl_q[tap];
		end else begin
			mul_c = b0_q;
			mul_d = v_q;
		end
	end

	assign prod_ext = {{(ACC_BITS-PROD_BITS){prod_q[PROD_BITS-1]}}, prod_q};

	// round half up, then saturate
	assign fb_rnd  = (fb_q + RND_HALF) >>> COEF_FRAC_BITS;
	assign acc_rnd = (acc_q + RND_HALF) >>> COEF_FRAC_BITS;

	always_comb begin
		v_clip = (fb_rnd > ST_HI) || (fb_rnd < ST_LO);
		if (fb_rnd > ST_HI)
			v_next = ST_HI[STATE_BITS-1:0];
		else if (fb_rnd < ST_LO)
			v_next = ST_LO[STATE_BITS-1:0];
		else
			v_next = fb_rnd[STATE_BITS-1:0];

		y_clip = (acc_rnd > SM_HI) || (acc_rnd < SM_LO);
		if (acc_rnd > SM_HI)
			y_next = SM_HI[SAMPLE_BITS-1:0];
		else if (acc_rnd < SM_LO)
			y_next = SM_LO[SAMPLE_BITS-1:0];
		else
			y_next = acc_rnd[SAMPLE_BITS-1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			ph_q    <= '0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					ph_q <= '0;
					if (req_acc && sample.op == OP_FILTER)
						state_q <= (ord_eff == '0) ? ST_VMUL : ST_MAC;
				end
				ST_MAC: begin
					if (ph_q == ph_last)
						state_q <= ST_DRAIN;
					else
						ph_q <= ph_q + PH_BITS'(1);
				end
				ST_DRAIN: state_q <= ST_VMUL;
				ST_VMUL:  state_q <= ST_VACC;
				ST_VACC:  state_q <= ST_FIN;
				ST_FIN: begin
					if (res_load)
						state_q <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// ---------------- datapath ----------------
	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				if (req_acc && sample.op == OP_FILTER) begin
					fb_q  <= {{X_PAD{sample.sample_in[SAMPLE_BITS-1]}}, sample.sample_in,
						COEF_FRAC_BITS'(0)};
					acc_q <= '0;
					hit_q <= 1'b0;
					// order 0 multiplies x straight by b0
					v_q   <= STATE_BITS'(sample.sample_in);
				end
			end
			ST_MAC: begin
				prod_q <= mul_c * mul_d;
				// add the product issued last cycle: a after even phase, b after odd
				if (ph_q != '0) begin
					if (ph_q[0])
						fb_q <= fb_q - prod_ext;
					else
						acc_q <= acc_q + prod_ext;
				end
			end
			ST_DRAIN: begin
				acc_q <= acc_q + prod_ext;
				v_q   <= v_next;
				hit_q <= v_clip;
			end
			ST_VMUL: prod_q <= mul_c * mul_d;
			ST_VACC: acc_q <= acc_q + prod_ext;
			default: ;
		endcase
	end

	// delay line: cleared by a clear request, shifted once v is known
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < MAX_ORDER; i++)
				dl_q[i] <= '0;
		end else if (req_acc && sample.op == OP_CLEAR) begin
			for (int i = 0; i < MAX_ORDER; i++)
				dl_q[i] <= '0;
		end else if (state_q == ST_DRAIN) begin
			dl_q[0] <= v_next;
			// taps beyond the order keep their contents
			for (int i = 1; i < MAX_ORDER; i++) begin
				if (ORDER_BITS'(i) < ord_eff)
					dl_q[i] <= dl_q[i-1];
			end
		end
	end

	// ---------------- result register ----------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			res_valid_q <= 1'b0;
		else if (res_load)
			res_valid_q <= 1'b1;
		else if (result.ready)
			res_valid_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (res_load) begin
			res_sample_q <= y_next;
			res_clip_q   <= hit_q || y_clip;
		end
	end

	assign result.valid      = res_valid_q;
	assign result.sample_out = res_sample_q;
	assign result.clipped    = res_clip_q;

endmodule

FILE: rtl/iirdf2_chk.sv
// ---------------------------------------------------------------------------
// IIR direct form II filter: port checker
// Watches the request and result channels of the top level; bound below.
// ---------------------------------------------------------------------------
`include "iir_direct_form_two_filter_defines.svh"

module iirdf2_chk import iirdf2_pkg::*; (
	input logic clk,
	input logic arst_n,
	input logic sample_valid,
	input logic sample_ready,
	input logic sample_op,
	input logic result_valid,
	input logic result_ready
);

	logic req_take;

	assign req_take = sample_valid && sample_ready;

	// a pending result stays offered until taken
	`IIRDF2_ASSERT(a_res_hold, result_valid && !result_ready |=> result_valid, "result dropped")

	// a filter request leaves the block busy in the cycle after it is taken
	`IIRDF2_ASSERT(a_busy_filter, req_take && sample_op == OP_FILTER |=> !sample_ready, "busy lost")

	// the block is ready again in the cycle after a clear request is taken
	`IIRDF2_ASSERT(a_clear_quick, req_take && sample_op == OP_CLEAR |=> sample_ready, "clear slow")

	// no result offered on the cycle after a reset cycle
	`IIRDF2_ASSERT_RST(a_rst_quiet, !arst_n |=> !result_valid, "result valid after reset")

endmodule

bind iir_direct_form_two_filter iirdf2_chk u_chk (
	.clk          (clk),
	.arst_n       (arst_n),
	.sample_valid (sample.valid),
	.sample_ready (sample.ready),
	.sample_op    (sample.op),
	.result_valid (result.valid),
	.result_ready (result.ready)
);
